// File: rtl/sbsi_pkg.sv
// Package: widths, payload structs, face codes and pipeline depth for the slab test core.
`timescale 1ns / 1ps
package sbsi_pkg;

    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;

    localparam int NUM_FACES = 6;
    localparam int NUM_AXES  = 3;

    // quotient bits taken before rounding: integer bit, F fraction bits, one guard bit
    localparam int DIV_STEPS = PARAM_FRAC_BITS + 2;

    // input register, setup, divider steps, round, multiply, contain, select
    localparam int LATENCY = DIV_STEPS + 6;

    localparam logic [2:0] FACE_NEG_X = 3'd0;
    localparam logic [2:0] FACE_POS_X = 3'd1;
    localparam logic [2:0] FACE_NEG_Y = 3'd2;
    localparam logic [2:0] FACE_POS_Y = 3'd3;
    localparam logic [2:0] FACE_NEG_Z = 3'd4;
    localparam logic [2:0] FACE_POS_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg_start_x;
        logic signed [COORD_BITS-1:0] seg_start_y;
        logic signed [COORD_BITS-1:0] seg_start_z;
        logic signed [COORD_BITS-1:0] seg_end_x;
        logic signed [COORD_BITS-1:0] seg_end_y;
        logic signed [COORD_BITS-1:0] seg_end_z;
        logic signed [COORD_BITS-1:0] box_min_x;
        logic signed [COORD_BITS-1:0] box_min_y;
        logic signed [COORD_BITS-1:0] box_min_z;
        logic signed [COORD_BITS-1:0] box_max_x;
        logic signed [COORD_BITS-1:0] box_max_y;
        logic signed [COORD_BITS-1:0] box_max_z;
    } query_t;

    typedef struct packed {
        logic                     hit;
        logic [PARAM_FRAC_BITS:0] hit_param;
        logic [2:0]               hit_face;
    } result_t;

endpackage

// File: rtl/segment_box_slab_intersection_core.sv
// Top level: pipelined segment versus axis-aligned box slab test.
`timescale 1ns / 1ps
//
//  channel   | signals                  | transfer when
//  ----------+--------------------------+------------------------------------
//  query     | start, busy, query       | start high and busy low at clk rise
//  result    | done, result             | done high, one cycle, cannot stall
//
//  One query is taken every cycle; busy is held low. The divider is
//  bit-per-stage, one stage per quotient bit, with six faces in
//  parallel lanes. Reset clears only the valid bits travelling with the data.
//  The receiver cannot stall, so the pipeline always advances.
//
module segment_box_slab_intersection_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sbsi_pkg::query_t  query,
    output logic              done,
    output sbsi_pkg::result_t result
);
    import sbsi_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = PARAM_FRAC_BITS;
    localparam int PW   = C + F + 3;   // product width
    localparam int XW   = C + 3;       // width of points on the segment
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

    // input register
    logic   in_v_reg;
    query_t in_q_reg;

    // setup stage and divider chain; index 0 is the setup output
    logic          dv_v_reg    [DIV_STEPS+1];
    query_t        dv_q_reg    [DIV_STEPS+1];
    logic          dv_cand_reg [DIV_STEPS+1][NUM_FACES];
    logic [C-1:0]  dv_den_reg  [DIV_STEPS+1][NUM_FACES];
    logic [C:0]    dv_rem_reg  [DIV_STEPS+1][NUM_FACES];
    logic [F+1:0]  dv_quo_reg  [DIV_STEPS+1][NUM_FACES];

    // rounded t
    logic          rt_v_reg;
    query_t        rt_q_reg;
    logic          rt_cand_reg [NUM_FACES];
    logic [F:0]    rt_tq_reg   [NUM_FACES];

    // products
    logic                 mu_v_reg;
    query_t               mu_q_reg;
    logic                 mu_cand_reg [NUM_FACES];
    logic [F:0]           mu_tq_reg   [NUM_FACES];
    logic signed [PW-1:0] mu_prod_reg [NUM_FACES][NUM_AXES];

    // containment
    logic       ct_v_reg;
    logic       ct_in_reg [NUM_FACES];
    logic [F:0] ct_tq_reg [NUM_FACES];

    // output
    logic    out_v_reg;
    result_t out_reg;

    assign busy   = 1'b0;
    assign done   = out_v_reg;
    assign result = out_reg;

    // select one coordinate of the query by point or bound selector and axis
    function automatic logic signed [C-1:0] pick(input query_t q, input int sel, input int ax);
        logic signed [C-1:0] v;
        v = '0;
        case (sel * NUM_AXES + ax)
            0:  v = q.seg_start_x;
            1:  v = q.seg_start_y;
            2:  v = q.seg_start_z;
            3:  v = q.seg_end_x;
            4:  v = q.seg_end_y;
            5:  v = q.seg_end_z;
            6:  v = q.box_min_x;
            7:  v = q.box_min_y;
            8:  v = q.box_min_z;
            9:  v = q.box_max_x;
            10: v = q.box_max_y;
            default: v = q.box_max_z;
        endcase
        return v;
    endfunction

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            rt_v_reg  <= 1'b0;
            mu_v_reg  <= 1'b0;
            ct_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dv_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            in_v_reg    <= start & ~busy;
            dv_v_reg[0] <= in_v_reg;
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                dv_v_reg[i] <= dv_v_reg[i-1];
            end
            rt_v_reg  <= dv_v_reg[DIV_STEPS];
            mu_v_reg  <= rt_v_reg;
            ct_v_reg  <= mu_v_reg;
            out_v_reg <= ct_v_reg;
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk)
    begin
        in_q_reg <= query;
    end

    // ---------------- setup: span, numerator, candidate flag ----------------
    logic         su_cand [NUM_FACES];
    logic [C-1:0] su_den  [NUM_FACES];
    logic [C:0]   su_rem  [NUM_FACES];

    always_comb
    begin
        logic signed [C:0] span;
        logic signed [C:0] num;
        logic signed [C-1:0] face;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            face = pick(in_q_reg, (f % 2 == 1) ? 3 : 2, f / 2);
            span = (C+1)'(pick(in_q_reg, 1, f / 2)) - (C+1)'(pick(in_q_reg, 0, f / 2));
            num  = (C+1)'(face) - (C+1)'(pick(in_q_reg, 0, f / 2));
            if (span < 0)
            begin
                span = -span;
                num  = -num;
            end
            su_cand[f] = (span != 0) && (num >= 0) && (num <= span);
            su_den[f]  = span[C-1:0];
            su_rem[f]  = {1'b0, num[C-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        dv_q_reg[0] <= in_q_reg;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            dv_cand_reg[0][f] <= su_cand[f];
            dv_den_reg[0][f]  <= su_den[f];
            dv_rem_reg[0][f]  <= su_rem[f];
            dv_quo_reg[0][f]  <= '0;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            logic [C:0] rr;
            logic       qb;
            dv_q_reg[k+1] <= dv_q_reg[k];
            for (int f = 0; f < NUM_FACES; f++)
            begin
                // first step takes the integer bit without doubling
                rr = (k == 0) ? dv_rem_reg[k][f] : (dv_rem_reg[k][f] << 1);
                qb = (rr >= {1'b0, dv_den_reg[k][f]});
                dv_cand_reg[k+1][f] <= dv_cand_reg[k][f];
                dv_den_reg[k+1][f]  <= dv_den_reg[k][f];
                dv_rem_reg[k+1][f]  <= qb ? (rr - {1'b0, dv_den_reg[k][f]}) : rr;
                dv_quo_reg[k+1][f]  <= {dv_quo_reg[k][f][F:0], qb};
            end
        end
    end

    // ---------------- round half up: drop the guard bit ----------------
    always_ff @(posedge clk)
    begin
        logic [F+2:0] q1;
        rt_q_reg <= dv_q_reg[DIV_STEPS];
        for (int f = 0; f < NUM_FACES; f++)
        begin
            q1 = {1'b0, dv_quo_reg[DIV_STEPS][f]} + (F+3)'(1);
            rt_cand_reg[f] <= dv_cand_reg[DIV_STEPS][f];
            rt_tq_reg[f]   <= q1[F+1:1];
        end
    end

    // ---------------- span times t on every axis ----------------
    always_ff @(posedge clk)
    begin
        logic signed [C:0]   d;
        logic signed [F+1:0] ts;
        mu_q_reg <= rt_q_reg;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            mu_cand_reg[f] <= rt_cand_reg[f];
            mu_tq_reg[f]   <= rt_tq_reg[f];
            ts = {1'b0, rt_tq_reg[f]};
            for (int a = 0; a < NUM_AXES; a++)
            begin
                d = (C+1)'(pick(rt_q_reg, 1, a)) - (C+1)'(pick(rt_q_reg, 0, a));
                mu_prod_reg[f][a] <= PW'(d) * PW'(ts);
            end
        end
    end

    // ---------------- containment of the crossing point ----------------
    always_ff @(posedge clk)
    begin
        logic signed [PW-1:0] pv;
        logic signed [XW-1:0] p;
        logic                 ok;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            ok = mu_cand_reg[f];
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (a == f / 2)
                begin
                    p = XW'(pick(mu_q_reg, (f % 2 == 1) ? 3 : 2, a));
                end
                else
                begin
                    pv = (mu_prod_reg[f][a] + HALF) >>> F;
                    p  = XW'(pick(mu_q_reg, 0, a)) + pv[XW-1:0];
                end
                if (p < XW'(pick(mu_q_reg, 2, a)) || p > XW'(pick(mu_q_reg, 3, a)))
                begin
                    ok = 1'b0;
                end
            end
            ct_in_reg[f] <= ok;
            ct_tq_reg[f] <= mu_tq_reg[f];
        end
    end

    // ---------------- pick smallest t, earlier face on ties ----------------
    always_ff @(posedge clk)
    begin
        logic       found;
        logic [F:0] best_t;
        logic [2:0] best_f;
        found  = 1'b0;
        best_t = '0;
        best_f = FACE_NEG_X;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            if (ct_in_reg[f] && (!found || ct_tq_reg[f] < best_t))
            begin
                found  = 1'b1;
                best_t = ct_tq_reg[f];
                best_f = 3'(f);
            end
        end
        out_reg.hit       <= found;
        out_reg.hit_param <= best_t;
        out_reg.hit_face  <= best_f;
    end

endmodule

// File: rtl/sbsi_checker.sv
// Checker: port-level properties of the slab test core, bound to the top level.
`timescale 1ns / 1ps
module sbsi_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input sbsi_pkg::query_t  query,
    input logic              done,
    input sbsi_pkg::result_t result
);
    import sbsi_pkg::*;

    localparam logic [PARAM_FRAC_BITS:0] T_ONE = (PARAM_FRAC_BITS+1)'(1) << PARAM_FRAC_BITS;

    // every transfer yields exactly one result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after query transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching query");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.hit_param == '0 && result.hit_face == FACE_NEG_X))
        else $error("miss carries nonzero fields");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hit_param <= T_ONE && result.hit_face <= FACE_POS_Z))
        else $error("result out of range");

endmodule

bind segment_box_slab_intersection_core sbsi_checker u_sbsi_checker (.*);

// File: sim/tb_top.sv
// Testbench for the segment versus box slab test core: random and directed queries.
`timescale 1ns / 1ps

// Scoreboard: holds the predicted answers in query order and compares each result.
class slab_scoreboard;
    sbsi_pkg::result_t pending_answers[$];
    int mismatches;
    int results_seen;
    int hits_seen;

    function new();
        mismatches   = 0;
        results_seen = 0;
        hits_seen    = 0;
    endfunction

    // Rounded point coordinate on axis k for quantised t.
    static function longint point_at(longint s, longint d, longint tq);
        longint prod;
        longint fl;
        prod = d * tq + (64'sd1 <<< (sbsi_pkg::PARAM_FRAC_BITS - 1));
        if (prod >= 0)
            fl = prod >>> sbsi_pkg::PARAM_FRAC_BITS;
        else
            fl = -((-prod + (64'sd1 <<< sbsi_pkg::PARAM_FRAC_BITS) - 1)
                   >>> sbsi_pkg::PARAM_FRAC_BITS);
        return s + fl;
    endfunction

    // Work out the first contained face crossing of the segment.
    static function sbsi_pkg::result_t slab_answer(sbsi_pkg::query_t q);
        sbsi_pkg::result_t r;
        longint s[3];
        longint e[3];
        longint lo[3];
        longint hi[3];
        longint face_v;
        longint span;
        longint num;
        longint tq;
        longint p;
        longint best_t;
        bit found;
        bit contained;
        int ax;
        int best_f;
        s[0] = q.seg_start_x;  s[1] = q.seg_start_y;  s[2] = q.seg_start_z;
        e[0] = q.seg_end_x;    e[1] = q.seg_end_y;    e[2] = q.seg_end_z;
        lo[0] = q.box_min_x;   lo[1] = q.box_min_y;   lo[2] = q.box_min_z;
        hi[0] = q.box_max_x;   hi[1] = q.box_max_y;   hi[2] = q.box_max_z;
        found = 0;
        best_t = 0;
        best_f = 0;
        for (int f = 0; f < sbsi_pkg::NUM_FACES; f++)
        begin
            ax = f >> 1;
            face_v = f[0] ? hi[ax] : lo[ax];
            span = e[ax] - s[ax];
            num = face_v - s[ax];
            if (span == 0)
                continue;
            if (span < 0)
            begin
                span = -span;
                num = -num;
            end
            if (num < 0 || num > span)
                continue;
            tq = ((num <<< (sbsi_pkg::PARAM_FRAC_BITS + 1)) + span) / (2 * span);
            contained = 1;
            for (int k = 0; k < sbsi_pkg::NUM_AXES; k++)
            begin
                p = (k == ax) ? face_v : point_at(s[k], e[k] - s[k], tq);
                if (p < lo[k] || p > hi[k])
                    contained = 0;
            end
            if (contained && (!found || tq < best_t))
            begin
                found = 1;
                best_t = tq;
                best_f = f;
            end
        end
        r.hit = found;
        r.hit_param = found ? best_t[sbsi_pkg::PARAM_FRAC_BITS:0] : '0;
        r.hit_face = found ? best_f[2:0] : '0;
        return r;
    endfunction

    function void note_query(sbsi_pkg::query_t q);
        pending_answers.push_back(slab_answer(q));
    endfunction

    function void report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endfunction

    function void check_result(sbsi_pkg::result_t got);
        sbsi_pkg::result_t want;
        results_seen++;
        if (got.hit)
            hits_seen++;
        if (pending_answers.size() == 0)
        begin
            report_mismatch("result with no query outstanding");
            return;
        end
        want = pending_answers.pop_front();
        if (got.hit !== want.hit)
            report_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
        if (got.hit_param !== want.hit_param)
            report_mismatch($sformatf("hit_param got %0d want %0d",
                                      got.hit_param, want.hit_param));
        if (got.hit_face !== want.hit_face)
            report_mismatch($sformatf("hit_face got %0d want %0d",
                                      got.hit_face, want.hit_face));
    endfunction
endclass

module tb_top;
    import sbsi_pkg::*;

    localparam int RANDOM_QUERIES = 1950;
    localparam longint CYCLE_LIMIT = 200000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    query_t  query;
    logic    done;
    result_t result;

    slab_scoreboard board;
    longint cycle_count;
    int queries_sent;

    segment_box_slab_intersection_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .query  (query),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Check every result strobe; the receiver cannot stall, so take each one.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_result(result);
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one query and hold it until a transfer occurs.
    task automatic send_query(query_t q);
        start <= 1'b1;
        query <= q;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        board.note_query(q);
        queries_sent++;
    endtask

    // Drop start for a number of cycles.
    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // A coordinate drawn near a small window so faces are often crossed.
    function automatic logic signed [15:0] near_coord(int centre, int spread);
        return 16'(centre + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic query_t make_box_query(int x0, int y0, int z0, int x1, int y1, int z1,
                                               int bx0, int by0, int bz0,
                                               int bx1, int by1, int bz1);
        query_t q;
        q.seg_start_x = 16'(x0);  q.seg_start_y = 16'(y0);  q.seg_start_z = 16'(z0);
        q.seg_end_x   = 16'(x1);  q.seg_end_y   = 16'(y1);  q.seg_end_z   = 16'(z1);
        q.box_min_x   = 16'(bx0); q.box_min_y   = 16'(by0); q.box_min_z   = 16'(bz0);
        q.box_max_x   = 16'(bx1); q.box_max_y   = 16'(by1); q.box_max_z   = 16'(bz1);
        return q;
    endfunction

    // Mostly boxes that the segment passes near, some wide-range and some inverted.
    function automatic query_t random_query();
        query_t q;
        int centre;
        int spread;
        int kind;
        logic signed [15:0] a;
        logic signed [15:0] b;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            q = query_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            return q;
        end
        centre = $signed($urandom_range(0, 60000)) - 30000;
        spread = (kind < 4) ? $urandom_range(1, 40) : $urandom_range(1, 2000);
        for (int k = 0; k < 3; k++)
        begin
            a = near_coord(centre, spread);
            b = near_coord(centre, spread);
            if (kind != 1 && a > b)
            begin
                q[(11 - 6 - k) * 16 +: 16] = b;
                q[(11 - 9 - k) * 16 +: 16] = a;
            end
            else
            begin
                q[(11 - 6 - k) * 16 +: 16] = a;
                q[(11 - 9 - k) * 16 +: 16] = b;
            end
            q[(11 - k) * 16 +: 16] = near_coord(centre, 2 * spread);
            // sometimes leave an axis with zero span
            q[(11 - 3 - k) * 16 +: 16] = ($urandom_range(0, 7) == 0) ?
                q[(11 - k) * 16 +: 16] : near_coord(centre, 2 * spread);
        end
        return q;
    endfunction

    initial
    begin
        query_t q;
        int burst;
        board = new();
        cycle_count = 0;
        queries_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        query = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each face entered, misses, zero spans, extremes, inverted boxes.
        send_query(make_box_query(-20, 0, 0, 20, 0, 0, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(20, 0, 0, -20, 0, 0, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(0, -20, 0, 0, 20, 0, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(0, 20, 0, 0, -20, 0, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(0, 0, -20, 0, 0, 20, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(0, 0, 20, 0, 0, -20, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(0, 0, 0, 5, 5, 5, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(3, 3, 3, 3, 3, 3, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(-20, 50, 0, 20, 50, 0, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(-20, -20, -20, 20, 20, 20, -10, -10, -10, 10, 10, 10));
        send_query(make_box_query(-20, 0, 0, 20, 0, 0, 10, 10, 10, -10, -10, -10));
        send_query(make_box_query(-32768, -32768, -32768, 32767, 32767, 32767,
                                  -32768, -32768, -32768, 32767, 32767, 32767));
        send_query(make_box_query(32767, 32767, 32767, -32768, -32768, -32768,
                                  0, 0, 0, 0, 0, 0));
        send_query(make_box_query(-32768, 1, -1, 32767, 2, -2,
                                  32767, -32768, -32768, 32767, 32767, 32767));
        send_query(make_box_query(0, 0, 0, 3, 1, 1, 1, 0, 0, 2, 1, 1));
        send_query(make_box_query(0, 0, 0, 1, 1, 1, 1, 1, 1, 2, 2, 2));
        send_query(make_box_query(-10, 0, 0, 10, 0, 0, -10, 0, 0, 10, 0, 0));
        send_query(make_box_query(0, 0, 0, 10, 0, 0, 11, -1, -1, 20, 1, 1));
        idle_cycles(1);

        // Pause until every outstanding result has come.
        while (board.pending_answers.size() != 0)
            @(posedge clk);

        // Random bursts with gaps; some bursts have no gaps at all.
        while (queries_sent < RANDOM_QUERIES + 18)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
                send_query(random_query());
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 30));
        end
        idle_cycles(1);

        // Drain, then allow the pipeline depth again for strays.
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("covered %0d queries, %0d results, %0d hits",
                 queries_sent, board.results_seen, board.hits_seen);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
